// File: rtl/glip_pkg.sv
// Shared types and constants for the grid longest increasing path block.
// No dependencies; imported by every module of the block.
`default_nettype none
package glip_pkg;
   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLUMNS = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int CELL_LIMIT  = MAX_ROWS * MAX_COLUMNS;
   localparam int CELL_BITS   = $clog2(CELL_LIMIT);
   localparam int COUNT_BITS  = $clog2(CELL_LIMIT + 1);
   localparam int DIM_BITS    = 6;
   localparam int LEN_BITS    = 11;
   localparam int ADDR_BITS   = 3;

   typedef enum logic [2:0] {
      RD_CENTER = 3'd0,
      RD_UP     = 3'd1,
      RD_RIGHT  = 3'd2,
      RD_DOWN   = 3'd3,
      RD_LEFT   = 3'd4
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      logic       clr_write;
      logic       pass_init;
      logic       issue;
      rd_sel_type rd_sel;
      logic       latch_center;
      logic       compare;
      logic       write_back;
      logic       result_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic cell_last;
      logic changed;
      logic out_free;
   } status_type;
endpackage
`default_nettype wire

// File: rtl/grid_longest_increasing_path.sv
// Evaluation: after the last cell, a clearing sweep over the rows*columns cells, then
// relaxation passes that read each cell and its four neighbours and write it back,
// repeated until a pass changes nothing (at most as many passes as the longest path),
// then the result is loaded once the output register is free.
// Throughput: one cell per cycle while loading; no cell is taken during evaluation.
// Reset is synchronous and active high; grid size registers reset to 32 by 32.
`default_nettype none
module grid_longest_increasing_path import glip_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0] req_cell_value,
   input  wire logic                          req_last_cell,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [LEN_BITS-1:0]                rsp_longest_path,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ADDR_BITS-1:0]          paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   logic [DIM_BITS-1:0] row_count_ff, column_count_ff;
   cmd_type    cmd;
   status_type status;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= DIM_BITS'(32);
         column_count_ff <= DIM_BITS'(32);
      end else if (psel && penable && pwrite) begin
         if (paddr[2]) begin
            column_count_ff <= pwdata[DIM_BITS-1:0];
         end else begin
            row_count_ff <= pwdata[DIM_BITS-1:0];
         end
      end
   end

   assign prdata = paddr[2] ? {26'd0, column_count_ff} : {26'd0, row_count_ff};

   glip_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_cell (req_last_cell),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   glip_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .row_count        (row_count_ff),
      .column_count     (column_count_ff),
      .req_cell_value   (req_cell_value),
      .req_last_cell    (req_last_cell),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_longest_path (rsp_longest_path)
   );
endmodule
`default_nettype wire

// File: rtl/glip_ctrl.sv
// Sequencer for loading, clearing and relaxation passes over the grid.
// Depends on glip_pkg; drives the datapath by command and status structs.
`default_nettype none
module glip_ctrl import glip_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last_cell,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_CLEAR = 10'b0000000010,
      ST_CTR   = 10'b0000000100,
      ST_N0    = 10'b0000001000,
      ST_N1    = 10'b0000010000,
      ST_N2    = 10'b0000100000,
      ST_N3    = 10'b0001000000,
      ST_LAST  = 10'b0010000000,
      ST_CHECK = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_CENTER;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            if (req_valid && req_last_cell) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               cmd.pass_init = 1'b1;
               state_in      = ST_CTR;
            end
         end
         ST_CTR: begin
            cmd.issue  = 1'b1;
            cmd.rd_sel = RD_CENTER;
            state_in   = ST_N0;
         end
         ST_N0: begin
            cmd.latch_center = 1'b1;
            cmd.issue        = 1'b1;
            cmd.rd_sel       = RD_UP;
            state_in         = ST_N1;
         end
         ST_N1: begin
            cmd.compare = 1'b1;
            cmd.issue   = 1'b1;
            cmd.rd_sel  = RD_RIGHT;
            state_in    = ST_N2;
         end
         ST_N2: begin
            cmd.compare = 1'b1;
            cmd.issue   = 1'b1;
            cmd.rd_sel  = RD_DOWN;
            state_in    = ST_N3;
         end
         ST_N3: begin
            cmd.compare = 1'b1;
            cmd.issue   = 1'b1;
            cmd.rd_sel  = RD_LEFT;
            state_in    = ST_LAST;
         end
         ST_LAST: begin
            cmd.write_back = 1'b1;
            state_in = status.cell_last ? ST_CHECK : ST_CTR;
         end
         ST_CHECK: begin
            if (status.changed) begin
               cmd.pass_init = 1'b1;
               state_in      = ST_CTR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/glip_dpath.sv
// Grid stores, cell counters, neighbour compare and result register.
// Depends on glip_pkg; steered by glip_ctrl through the command struct.
`default_nettype none
module glip_dpath import glip_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [DIM_BITS-1:0]           row_count,
   input  wire logic [DIM_BITS-1:0]           column_count,
   input  wire logic signed [VALUE_WIDTH-1:0] req_cell_value,
   input  wire logic                          req_last_cell,
   input  wire cmd_type                       cmd,
   output status_type                         status,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [LEN_BITS-1:0]                rsp_longest_path
);
   logic [DIM_BITS-1:0]   rows, cols;
   logic [COUNT_BITS-1:0] count;

   always_comb begin
      priority if (row_count == '0) rows = DIM_BITS'(1);
      else if (row_count > DIM_BITS'(MAX_ROWS)) rows = DIM_BITS'(MAX_ROWS);
      else rows = row_count;
      priority if (column_count == '0) cols = DIM_BITS'(1);
      else if (column_count > DIM_BITS'(MAX_COLUMNS)) cols = DIM_BITS'(MAX_COLUMNS);
      else cols = column_count;
   end

   assign count = COUNT_BITS'(rows) * COUNT_BITS'(cols);

   logic signed [VALUE_WIDTH-1:0] value_mem [CELL_LIMIT];
   logic [LEN_BITS-1:0]           path_mem  [CELL_LIMIT];
   logic signed [VALUE_WIDTH-1:0] vdata_ff;
   logic [LEN_BITS-1:0]           pdata_ff;

   logic [COUNT_BITS-1:0] load_pos_ff, load_pos_in, load_at, load_next;

   always_comb begin
      load_at   = (load_pos_ff >= count) ? '0 : load_pos_ff;
      load_next = load_at + COUNT_BITS'(1);
      if (req_last_cell || load_next >= count) begin
         load_pos_in = '0;
      end else begin
         load_pos_in = load_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
      end else if (cmd.load) begin
         load_pos_ff <= load_pos_in;
      end
   end

   logic [COUNT_BITS-1:0] clr_ff;
   logic [CELL_BITS-1:0]  cell_ff;
   logic [DIM_BITS-1:0]   row_ff, col_ff;
   logic                  changed_ff, nb_ok_ff, nb_ok_in;
   logic [LEN_BITS-1:0]   best_ff, acc_ff, orig_ff, cand, acc_new;
   logic signed [VALUE_WIDTH-1:0] ctr_val_ff;
   logic [CELL_BITS-1:0]  rd_addr;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_UP: begin
            rd_addr  = cell_ff - CELL_BITS'(cols);
            nb_ok_in = row_ff != '0;
         end
         RD_RIGHT: begin
            rd_addr  = cell_ff + CELL_BITS'(1);
            nb_ok_in = col_ff != cols - DIM_BITS'(1);
         end
         RD_DOWN: begin
            rd_addr  = cell_ff + CELL_BITS'(cols);
            nb_ok_in = row_ff != rows - DIM_BITS'(1);
         end
         RD_LEFT: begin
            rd_addr  = cell_ff - CELL_BITS'(1);
            nb_ok_in = col_ff != '0;
         end
         default: begin
            rd_addr  = cell_ff;
            nb_ok_in = 1'b1;
         end
      endcase
   end

   always_comb begin
      cand    = pdata_ff + LEN_BITS'(1);
      acc_new = acc_ff;
      if (nb_ok_ff && vdata_ff > ctr_val_ff && cand > acc_ff) begin
         acc_new = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_mem[load_at[CELL_BITS-1:0]] <= req_cell_value;
      end
      if (cmd.clr_write) begin
         path_mem[clr_ff[CELL_BITS-1:0]] <= LEN_BITS'(1);
      end else if (cmd.write_back) begin
         path_mem[cell_ff] <= acc_new;
      end
      if (cmd.issue) begin
         vdata_ff <= value_mem[rd_addr];
         pdata_ff <= path_mem[rd_addr];
         nb_ok_ff <= nb_ok_in;
      end
      if (cmd.latch_center) begin
         ctr_val_ff <= vdata_ff;
         acc_ff     <= pdata_ff;
         orig_ff    <= pdata_ff;
      end else if (cmd.compare) begin
         acc_ff <= acc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         cell_ff    <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         changed_ff <= 1'b0;
         best_ff    <= LEN_BITS'(1);
      end else begin
         if (cmd.load) begin
            clr_ff <= '0;
         end else if (cmd.clr_write) begin
            clr_ff <= clr_ff + COUNT_BITS'(1);
         end
         if (cmd.pass_init) begin
            cell_ff    <= '0;
            row_ff     <= '0;
            col_ff     <= '0;
            changed_ff <= 1'b0;
            best_ff    <= LEN_BITS'(1);
         end else if (cmd.write_back) begin
            cell_ff <= cell_ff + CELL_BITS'(1);
            if (col_ff == cols - DIM_BITS'(1)) begin
               col_ff <= '0;
               row_ff <= row_ff + DIM_BITS'(1);
            end else begin
               col_ff <= col_ff + DIM_BITS'(1);
            end
            if (acc_new != orig_ff) begin
               changed_ff <= 1'b1;
            end
            if (acc_new > best_ff) begin
               best_ff <= acc_new;
            end
         end
      end
   end

   logic                rsp_valid_ff;
   logic [LEN_BITS-1:0] rsp_path_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.result_load) begin
         rsp_path_ff <= best_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_longest_path = rsp_path_ff;

   assign status.clr_last  = clr_ff == count - COUNT_BITS'(1);
   assign status.cell_last = COUNT_BITS'(cell_ff) == count - COUNT_BITS'(1);
   assign status.changed   = changed_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
endmodule
`default_nettype wire

// File: rtl/glip_checker.sv
// Port-level checks for grid_longest_increasing_path, bound to the top level.
// Depends on glip_pkg for widths.
`default_nettype none
module glip_checker import glip_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                req_last_cell,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [LEN_BITS-1:0] rsp_longest_path
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_longest_path))
      else $error("Result transaction changed while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_longest_path != '0 && rsp_longest_path <= LEN_BITS'(CELL_LIMIT))
      else $error("Result length out of range.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_cell |=> req_stall)
      else $error("Input taken while the grid is being evaluated.");
endmodule

bind grid_longest_increasing_path glip_checker u_glip_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_cell    (req_last_cell),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_longest_path (rsp_longest_path)
);
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for grid_longest_increasing_path: a directed table, then random grids.
// Depends on glip_pkg and the block's RTL; results are checked against an in-bench path predictor.
`default_nettype none
module tb_top import glip_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ADDR_BITS-1:0] ROWS_ADDR = 3'd0;
   localparam logic [ADDR_BITS-1:0] COLS_ADDR = 3'd4;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic {ROW_CFG, ROW_CELL} row_kind_type;
   typedef struct {
      row_kind_type            kind;
      logic [ADDR_BITS-1:0]    addr;
      logic signed [31:0]      data;
      logic                    last;
      int                      want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VALUE_WIDTH-1:0] req_cell_value = '0;
   logic req_last_cell = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [LEN_BITS-1:0] rsp_longest_path;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   grid_longest_increasing_path dut (.*);

   always #5 clock = ~clock;

   logic signed [VALUE_WIDTH-1:0] cell_mem [CELL_LIMIT];
   int unsigned path_len [CELL_LIMIT];
   logic [DIM_BITS-1:0] row_reg = 6'd32, col_reg = 6'd32;
   int unsigned load_pos = 0;
   int unsigned high_water = 0;
   logic [LEN_BITS-1:0] longest_q [$];
   int errors = 0;
   int unsigned cycles = 0;
   stim_row_type table_rows [$];

   function automatic int unsigned used_dim(logic [DIM_BITS-1:0] r, int unsigned top);
      if (r == 0) return 1;
      if (r > top) return top;
      return r;
   endfunction

   function automatic int unsigned grid_longest();
      int unsigned rows, cols, best, longest, pos, nb;
      int nr, nc;
      bit changed;
      rows = used_dim(row_reg, MAX_ROWS);
      cols = used_dim(col_reg, MAX_COLUMNS);
      for (int i = 0; i < rows * cols; i++) path_len[i] = 1;
      do begin
         changed = 0;
         for (pos = 0; pos < rows * cols; pos++) begin
            longest = 0;
            for (int d = 0; d < 4; d++) begin
               nr = int'(pos / cols) + (d == 0 ? -1 : d == 2 ? 1 : 0);
               nc = int'(pos % cols) + (d == 1 ? 1 : d == 3 ? -1 : 0);
               if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
               nb = nr * cols + nc;
               if (cell_mem[nb] > cell_mem[pos] && path_len[nb] > longest)
                  longest = path_len[nb];
            end
            if (longest + 1 != path_len[pos]) begin
               path_len[pos] = longest + 1;
               changed = 1;
            end
         end
      end while (changed);
      best = 1;
      for (int i = 0; i < rows * cols; i++) if (path_len[i] > best) best = path_len[i];
      return best > 2047 ? 2047 : best;
   endfunction

   function automatic void take_cell(logic signed [31:0] v, logic last, int want);
      int unsigned count, got;
      count = used_dim(row_reg, MAX_ROWS) * used_dim(col_reg, MAX_COLUMNS);
      if (load_pos >= count) load_pos = 0;
      cell_mem[load_pos] = v;
      load_pos++;
      if (load_pos > high_water) high_water = load_pos;
      if (!last) begin
         if (load_pos >= count) load_pos = 0;
      end else begin
         got = grid_longest();
         longest_q.push_back(want >= 0 ? want[LEN_BITS-1:0] : got[LEN_BITS-1:0]);
         load_pos = 0;
      end
   endfunction

   task automatic send_cell(logic signed [31:0] v, logic last, int want);
      req_valid <= 1'b1;
      req_cell_value <= v;
      req_last_cell <= last;
      do @(posedge clock); while (req_stall);
      take_cell(v, last, want);
   endtask

   task automatic sender_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (longest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [ADDR_BITS-1:0] a, logic [31:0] d);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (a == ROWS_ADDR) row_reg = d[DIM_BITS-1:0];
      else col_reg = d[DIM_BITS-1:0];
   endtask

   function automatic logic signed [31:0] pick_value(int style);
      case (style)
         0: return $signed($urandom_range(0, 6)) - 3;
         1: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic void add_row(row_kind_type k, logic [ADDR_BITS-1:0] a,
                                   logic signed [31:0] d, logic l, int w);
      stim_row_type r;
      r.kind = k; r.addr = a; r.data = d; r.last = l; r.want = w;
      table_rows.push_back(r);
   endfunction

   // Receiver: stall pattern alternates between free, light and heavy stretches.
   int unsigned stall_left = 0;
   int unsigned stall_pct = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(5, 60);
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 80);
      end
      stall_left--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (longest_q.size() == 0) begin
            $error("unexpected transaction: longest_path actual %0d", rsp_longest_path);
            errors++;
         end else begin
            if (rsp_longest_path !== longest_q[0]) begin
               $error("longest_path expected %0d actual %0d", longest_q[0], rsp_longest_path);
               errors++;
            end
            void'(longest_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("grid_longest_increasing_path verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned sent, count, n, rows, cols;
      int style;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(ROW_CFG, ROWS_ADDR, 0, 0, -1);
      add_row(ROW_CFG, COLS_ADDR, 0, 0, -1);
      add_row(ROW_CELL, 0, 32'sh80000000, 1, 1);
      add_row(ROW_CFG, COLS_ADDR, 2, 0, -1);
      add_row(ROW_CELL, 0, 0, 0, -1);
      add_row(ROW_CELL, 0, 1, 1, 2);
      add_row(ROW_CELL, 0, 5, 0, -1);
      add_row(ROW_CELL, 0, 5, 1, 1);
      add_row(ROW_CFG, ROWS_ADDR, 2, 0, -1);
      add_row(ROW_CELL, 0, 32'sh7fffffff, 0, -1);
      add_row(ROW_CELL, 0, 32'sh80000000, 0, -1);
      add_row(ROW_CELL, 0, 32'sh80000000, 0, -1);
      add_row(ROW_CELL, 0, 32'sh7fffffff, 1, 2);
      // An early last mark reuses the older cells of the grid.
      add_row(ROW_CELL, 0, 7, 1, -1);
      // Six cells into a four-cell grid wrap round the store.
      for (int i = 0; i < 6; i++) add_row(ROW_CELL, 0, $signed(i) - 2, 0, -1);
      add_row(ROW_CELL, 0, -9, 1, -1);
      add_row(ROW_CFG, ROWS_ADDR, 63, 0, -1);
      add_row(ROW_CFG, COLS_ADDR, 1, 0, -1);

      foreach (table_rows[i]) begin
         if (table_rows[i].kind == ROW_CFG) begin
            wait_idle();
            csr_write(table_rows[i].addr, table_rows[i].data);
         end else begin
            send_cell(table_rows[i].data, table_rows[i].last, table_rows[i].want);
            if ($urandom_range(0, 2) == 0) sender_gap();
         end
      end
      for (int i = 0; i < 32; i++) send_cell(i, i == 31, 32);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0 || sent == 0) begin
            wait_idle();
            case ($urandom_range(0, 9))
               0: begin rows = 0; cols = $urandom_range(0, 63); end
               1: begin rows = $urandom_range(33, 63); cols = 1; end
               2: begin rows = (sent > 400 && sent < 460) ? 32 : 3; cols = rows; end
               default: begin rows = $urandom_range(1, 6); cols = $urandom_range(1, 6); end
            endcase
            csr_write(ROWS_ADDR, rows);
            csr_write(COLS_ADDR, cols);
         end
         count = used_dim(row_reg, MAX_ROWS) * used_dim(col_reg, MAX_COLUMNS);
         case ($urandom_range(0, 7))
            0: n = (high_water >= count && count > 1) ? $urandom_range(1, count - 1) : count;
            1: n = count + $urandom_range(1, 5);
            default: n = count;
         endcase
         style = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) begin
            send_cell(pick_value(style == 1 ? ($urandom_range(0, 3) == 0 ? 1 : 2) : style),
                      i == n - 1, -1);
            sent++;
            if ($urandom_range(0, 5) == 0) sender_gap();
         end
         if ($urandom_range(0, 1) == 0) sender_gap();
      end

      wait_idle();
      if (errors == 0) begin
         $display("grid_longest_increasing_path verification clean");
      end else begin
         $display("grid_longest_increasing_path verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
